// ===== rtl/isqn_pkg.sv =====
// ----------------------------------------------------------------------------
// isqn_pkg
// Shared types, widths and constants for the Newton integer square root block.
// ----------------------------------------------------------------------------
package isqn_pkg;

	localparam int DATA_W = 32;
	localparam int ROOT_W = 16;
	localparam int MAG_W  = DATA_W - 1;

	typedef logic signed [DATA_W-1:0] value_t;
	typedef logic [DATA_W-1:0]        word_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [ROOT_W-1:0]        root_t;

	localparam mag_t GUESS_HI  = mag_t'(32'h0000_3FFF);
	localparam mag_t GUESS_MID = mag_t'(32'h0000_03FF);
	localparam mag_t GUESS_LO  = mag_t'(32'h0000_003F);
	localparam mag_t GUESS_MIN = mag_t'(32'h0000_0007);
	localparam mag_t SMALL_MAX = mag_t'(32'h0000_0004);

	// starting guess by magnitude of a positive operand
	function automatic mag_t init_guess(input mag_t v);
		mag_t g;
		begin
			if (v[30:16] != '0) begin
				g = (v[30:24] != '0) ? GUESS_HI : GUESS_MID;
			end else if (v[15:8] != '0) begin
				g = GUESS_LO;
			end else begin
				g = (v > SMALL_MAX) ? GUESS_MIN : v;
			end
			return g;
		end
	endfunction

endpackage

// ===== rtl/isqn_div.sv =====
// ----------------------------------------------------------------------------
// isqn_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module isqn_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  isqn_pkg::word_t dividend,
	input  isqn_pkg::word_t divisor,
	output logic            done,
	output isqn_pkg::word_t quotient,
	output isqn_pkg::word_t remainder
);
	import isqn_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            q_q;
	word_t            r_q;
	word_t            d_q;
	logic [DATA_W:0]  trial;

	assign trial = {r_q, q_q[DATA_W-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				r_q <= trial[DATA_W-1:0];
				q_q <= {q_q[DATA_W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[DATA_W-2:0], q_q[DATA_W-1]};
				q_q <= {q_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = r_q;

endmodule

// ===== rtl/integer_sqrt_newton.sv =====
// ----------------------------------------------------------------------------
// integer_sqrt_newton
// Integer square root of a signed 32-bit value by Newton iteration.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   input    | in_valid / in_stall  | value  (32b signed)
//   output   | out_valid / out_stall| root   (16b unsigned)
//
// One beat at a time. Each Newton step runs one pass of the shared radix-2
// divider, plus the ST_STEP state to form the next guess; the last step
// is followed by one more division for the exact k*(k-1) correction.
// Zero or negative values skip the divider and go straight to ST_FIN;
// in_stall is high while an item is in work.
// Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module integer_sqrt_newton (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  isqn_pkg::value_t value,
	output logic             out_valid,
	input  logic             out_stall,
	output isqn_pkg::root_t  root
);
	import isqn_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_STEP = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]     state_q;
	mag_t           v_q;
	mag_t           best_q;
	mag_t           guess_q;
	root_t          res_q;
	root_t          root_q;
	logic           out_valid_q;

	logic           div_start;
	word_t          div_divisor;
	logic           div_done;
	word_t          div_quo;
	word_t          div_rem;

	logic [DATA_W:0] sum;
	word_t           next_guess;
	logic            improves;
	logic            accept;
	logic            out_free;
	logic            positive;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign positive = (value != '0) && !value[DATA_W-1];
	assign out_free = !out_valid_q || !out_stall;

	assign sum        = {1'b0, div_quo} + {2'b00, guess_q};
	assign next_guess = sum[DATA_W:1] + word_t'(sum[0]);
	assign improves   = {1'b0, best_q} > next_guess;

	always_comb begin
		div_start   = 1'b0;
		div_divisor = {1'b0, guess_q};
		unique case (state_q)
			ST_IDLE: begin
				div_start   = accept && positive;
				div_divisor = {1'b0, init_guess(value[MAG_W-1:0])};
			end
			ST_STEP: begin
				div_start   = 1'b1;
				div_divisor = improves ? next_guess : {1'b0, best_q};
			end
			default: begin
				div_start   = 1'b0;
				div_divisor = {1'b0, guess_q};
			end
		endcase
	end

	isqn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  ({1'b0, (state_q == ST_IDLE) ? value[MAG_W-1:0] : v_q}),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= positive ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					state_q <= improves ? ST_DIV : ST_CHK;
				end
				ST_CHK: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				v_q     <= value[MAG_W-1:0];
				best_q  <= value[MAG_W-1:0];
				guess_q <= init_guess(value[MAG_W-1:0]);
				res_q   <= '0;
			end
			ST_STEP: begin
				if (improves) begin
					best_q  <= next_guess[MAG_W-1:0];
					guess_q <= next_guess[MAG_W-1:0];
				end
			end
			ST_CHK: begin
				if (div_done) begin
					// exact k*(k-1) correction: the guess lands one high
					if ((div_quo == {1'b0, best_q - 1'b1}) && (div_rem == '0)) begin
						res_q <= root_t'(best_q - 1'b1);
					end else begin
						res_q <= root_t'(best_q);
					end
				end
			end
			ST_FIN: begin
				if (out_free) begin
					root_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign root      = root_q;

endmodule

// ===== bench/integer_sqrt_newton_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_sqrt_newton_tb
// Self-checking bench for the Newton integer square root block. A queue-fed
// driver sends operands, and a monitor compares each root with the result of
// an in-bench Newton iteration. It covers directed edge values and random
// magnitude classes, including squares and near-squares. The run goes through
// phases of sender idling and receiver stalling, plus one long output hold.
// ----------------------------------------------------------------------------
module integer_sqrt_newton_tb;

	import isqn_pkg::*;

	localparam int HOLD_CYCLES   = 600;
	localparam int DRAIN_CYCLES  = 300;

	typedef enum int {
		PH_DIRECTED,
		PH_FREE,
		PH_TX_IDLE,
		PH_RX_STALL,
		PH_BOTH,
		PH_PRESSURE
	} phase_e;

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    in_valid  = 1'b0;
	logic    in_stall;
	value_t  value     = '0;
	logic    out_valid;
	logic    out_stall = 1'b0;
	root_t   root;

	value_t  pending_values [$];
	root_t   roots_due [$];
	phase_e  phase        = PH_DIRECTED;
	int      tx_idle_pct  = 0;
	int      rx_stall_pct = 0;
	int      hold_left    = HOLD_CYCLES;
	int      fail_count   = 0;

	word_t   directed_words [0:23] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd8, 32'd9, 32'd12,
		32'd255, 32'd256, 32'd65535, 32'd65536, 32'h00FF_FFFF, 32'h0100_0000,
		32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
		32'd2147395600, 32'd2147441940, 32'hAAAA_AAAA, 32'd2147395599
	};

	integer_sqrt_newton u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.root      (root)
	);

	always #5 clk = ~clk;

	function automatic root_t predict_root(input value_t v);
		word_t           u;
		word_t           guess;
		word_t           best;
		logic [DATA_W:0] sum;
		bit              done;
		u = word_t'(v);
		if (v <= 0)
			return '0;
		best = u;
		if (u[31:16] != '0)
			guess = (u[31:24] != '0) ? word_t'(GUESS_HI) : word_t'(GUESS_MID);
		else if (u[15:8] != '0)
			guess = word_t'(GUESS_LO);
		else
			guess = (u > word_t'(SMALL_MAX)) ? word_t'(GUESS_MIN) : u;
		done = 1'b0;
		while (!done) begin
			if (guess == '0)
				guess = word_t'(1);
			sum = {1'b0, u / guess} + {1'b0, guess};
			guess = word_t'((sum >> 1) + sum[0]);
			if (best > guess) begin
				best = guess;
			end else begin
				// exact k*(k-1) lands one high
				if (best != '0 && u / best == best - 1 && u % best == '0)
					best = best - 1;
				done = 1'b1;
			end
		end
		return root_t'(best);
	endfunction

	function automatic value_t random_value();
		word_t k;
		word_t w;
		case ($urandom_range(9))
			0: w = $urandom();
			1: w = {1'b1, 31'($urandom())};
			2: w = $urandom_range(4);
			3: w = $urandom_range(255, 5);
			4: w = $urandom_range(65535, 256);
			5: w = $urandom_range(32'h00FF_FFFF, 32'h0001_0000);
			6: w = $urandom_range(32'h7FFF_FFFF, 32'h0100_0000);
			7: begin
				k = $urandom_range(46340, 1);
				w = k * k + $urandom_range(2) - 1;
			end
			8: begin
				k = $urandom_range(46341, 2);
				w = k * (k - 1);
			end
			default: begin
				k = $urandom_range(300, 1);
				w = k * k + $urandom_range(2) - 1;
			end
		endcase
		return value_t'(w);
	endfunction

	// sender: next beat loads once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value    <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				roots_due.push_back(predict_root(value));
			if (pending_values.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				value    <= pending_values.pop_front();
			end else begin
				in_valid <= 1'b0;
				value    <= $urandom();
			end
		end
	end

	// receiver: random stalls, one long hold in the pressure phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (phase == PH_PRESSURE && hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		root_t want_root;
		if (arst_n && out_valid && !out_stall) begin
			if (roots_due.size() == 0) begin
				$error("root: beat with nothing due, actual %0d", root);
				fail_count++;
			end else begin
				want_root = roots_due.pop_front();
				if (root !== want_root) begin
					$error("root: expected %0d, actual %0d", want_root, root);
					fail_count++;
				end
			end
		end
	end

	task automatic run_phase(input phase_e ph, input int tx_pct, input int rx_pct,
			input int count);
		phase        = ph;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		if (ph == PH_DIRECTED) begin
			foreach (directed_words[i])
				pending_values.push_back(value_t'(directed_words[i]));
		end else begin
			repeat (count)
				pending_values.push_back(random_value());
		end
		do
			@(negedge clk);
		while (pending_values.size() != 0 || in_valid || roots_due.size() != 0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_phase(PH_DIRECTED, 0, 0, 0);
		run_phase(PH_FREE, 0, 0, 200);
		run_phase(PH_TX_IDLE, 69, 0, 180);
		run_phase(PH_RX_STALL, 0, 69, 180);
		run_phase(PH_BOTH, 29, 29, 200);
		run_phase(PH_PRESSURE, 0, 0, 190);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
